@@ rtl/core/key_autorepeat_engine_top_macros.svh @@
// Assertion macros shared by the key auto-repeat engine RTL.
`ifndef KEY_AUTOREPEAT_ENGINE_TOP_MACROS_SVH
`define KEY_AUTOREPEAT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KAR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define KAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kar_pkg.sv @@
// Package with constants and types of the key auto-repeat engine.
package kar_pkg;

  // Field widths.
  localparam int unsigned DelayW   = 16;
  localparam int unsigned TermW    = 8;
  localparam int unsigned ClassW   = 5;
  localparam int unsigned KeyW     = 16;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned MaxSlots = 4;
  localparam int unsigned SetBits  = MaxSlots * SlotW;

  // Default number of slots in each boosted key set.
  localparam int unsigned BoostSlotsDef = 4;

  // Reset values of timing registers.
  localparam logic [DelayW-1:0] DelayRst = DelayW'(150);
  localparam logic [TermW-1:0]  TermRst  = TermW'(6);

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegNormalDelay = 3'd0;
  localparam logic [CfgAddrW-1:0] RegNormalTerm  = 3'd1;
  localparam logic [CfgAddrW-1:0] RegBoost1Delay = 3'd2;
  localparam logic [CfgAddrW-1:0] RegBoost1Term  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegBoost2Delay = 3'd4;
  localparam logic [CfgAddrW-1:0] RegBoost2Term  = 3'd5;
  localparam logic [CfgAddrW-1:0] RegClassEnable = 3'd6;
  localparam logic [CfgAddrW-1:0] RegBoostSlots  = 3'd7;

  // Result kinds.
  localparam logic [KindW-1:0] KindNone    = 2'd0;
  localparam logic [KindW-1:0] KindPress   = 2'd1;
  localparam logic [KindW-1:0] KindRelease = 2'd2;

  // Input actions.
  localparam logic ActKey  = 1'b0;
  localparam logic ActTick = 1'b1;

  // Key code class bounds.
  localparam logic [KeyW-1:0] CodeLetterLo = 16'h0004;
  localparam logic [KeyW-1:0] CodeLetterHi = 16'h001D;
  localparam logic [KeyW-1:0] CodeDigitLo  = 16'h001E;
  localparam logic [KeyW-1:0] CodeDigitHi  = 16'h0027;
  localparam logic [KeyW-1:0] CodeCtrlLo   = 16'h0028;
  localparam logic [KeyW-1:0] CodeCtrlHi   = 16'h0039;
  localparam logic [KeyW-1:0] CodeFLowLo   = 16'h003A;
  localparam logic [KeyW-1:0] CodeFLowHi   = 16'h0045;
  localparam logic [KeyW-1:0] CodeFHighLo  = 16'h0068;
  localparam logic [KeyW-1:0] CodeFHighHi  = 16'h0073;

  // Class enable bits.
  localparam int unsigned ClsLetters = 0;
  localparam int unsigned ClsDigits  = 1;
  localparam int unsigned ClsCtrl    = 2;
  localparam int unsigned ClsFkeys   = 3;
  localparam int unsigned ClsAll     = 4;

  // One registered input word.
  typedef struct packed {
    logic             action;
    logic [KeyW-1:0]  keycode;
    logic             key_down;
    logic             fast_layer_on;
    logic [TimeW-1:0] now_ms;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [KindW-1:0] emit_kind;
    logic [CodeW-1:0] emit_code;
    logic             pass_through;
  } out_word_t;

endpackage

@@ rtl/core/key_autorepeat_engine_top.sv @@
// Key auto-repeat engine: turns key events and scan ticks into repeat presses and releases.
//
// Each word on the input channel is a key event or a scan tick and gives exactly one
// result word. A word is taken into an input register, the press/release decision and
// the hold state update are made in compare logic, and the result lands in an output
// register: one word per clock is sustained while out_ready stays high, and each result
// passes the input register and then the output register before it is shown, later if
// an earlier result still waits for out_ready. The output register lets a new word enter
// while a finished result still waits for out_ready. The user must write timing registers
// through the cfg_ port only while no word is in flight; the block does not enforce this.
module key_autorepeat_engine_top
  import kar_pkg::*;
#(
  parameter int unsigned BOOST_SLOTS = BoostSlotsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [KeyW-1:0]     in_keycode,
  input  logic                in_key_down,
  input  logic                in_fast_layer_on,
  input  logic [TimeW-1:0]    in_now_ms,
  // Result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KindW-1:0]    out_emit_kind,
  output logic [CodeW-1:0]    out_emit_code,
  output logic                out_pass_through
);

  localparam int unsigned NumSlots = (BOOST_SLOTS > MaxSlots) ? MaxSlots : BOOST_SLOTS;
  localparam int unsigned UsedBits = NumSlots * SlotW;

  // Configuration registers.
  logic [DelayW-1:0]   normal_delay_r, boost1_delay_r, boost2_delay_r;
  logic [TermW-1:0]    normal_term_r, boost1_term_r, boost2_term_r;
  logic [ClassW-1:0]   class_enable_r;
  logic [UsedBits-1:0] boost1_slots_r, boost2_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_delay_r <= DelayRst;
      normal_term_r  <= TermRst;
      boost1_delay_r <= DelayRst;
      boost1_term_r  <= TermRst;
      boost2_delay_r <= DelayRst;
      boost2_term_r  <= TermRst;
      class_enable_r <= '0;
      boost1_slots_r <= '0;
      boost2_slots_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegNormalDelay: normal_delay_r <= cfg_wdata[DelayW-1:0];
        RegNormalTerm:  normal_term_r  <= cfg_wdata[TermW-1:0];
        RegBoost1Delay: boost1_delay_r <= cfg_wdata[DelayW-1:0];
        RegBoost1Term:  boost1_term_r  <= cfg_wdata[TermW-1:0];
        RegBoost2Delay: boost2_delay_r <= cfg_wdata[DelayW-1:0];
        RegBoost2Term:  boost2_term_r  <= cfg_wdata[TermW-1:0];
        RegClassEnable: class_enable_r <= cfg_wdata[ClassW-1:0];
        RegBoostSlots: begin
          boost1_slots_r <= cfg_wdata[UsedBits-1:0];
          boost2_slots_r <= cfg_wdata[SetBits +: UsedBits];
        end
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the output register is free or drains.
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= '{action: in_action, keycode: in_keycode, key_down: in_key_down,
                     fast_layer_on: in_fast_layer_on, now_ms: in_now_ms};
    end
  end

  // Hold state.
  logic              holding_r, repeating_r, press_sent_r;
  logic [CodeW-1:0]  held_code_r;
  logic [TimeW-1:0]  stamp_ms_r;
  logic [DelayW-1:0] active_delay_r;
  logic [TermW-1:0]  active_term_r;

  logic              holding_nxt, repeating_nxt, press_sent_nxt;
  logic [CodeW-1:0]  held_code_nxt;
  logic [TimeW-1:0]  stamp_ms_nxt;
  logic [DelayW-1:0] active_delay_nxt;
  logic [TermW-1:0]  active_term_nxt;
  out_word_t         result;

  // Class filter on the full key code.
  logic [KeyW-1:0] kc;
  logic            code_en;
  logic [CodeW-1:0] kc8;

  assign kc  = in_word_r.keycode;
  assign kc8 = kc[CodeW-1:0];

  always_comb begin
    code_en = 1'b0;
    if (class_enable_r[ClsAll] && kc >= CodeLetterLo && kc <= CodeFHighHi) code_en = 1'b1;
    if (class_enable_r[ClsLetters] && kc >= CodeLetterLo && kc <= CodeLetterHi) code_en = 1'b1;
    if (class_enable_r[ClsDigits] && kc >= CodeDigitLo && kc <= CodeDigitHi) code_en = 1'b1;
    if (class_enable_r[ClsCtrl] && kc >= CodeCtrlLo && kc <= CodeCtrlHi) code_en = 1'b1;
    if (class_enable_r[ClsFkeys] && ((kc >= CodeFLowLo && kc <= CodeFLowHi) ||
                                     (kc >= CodeFHighLo && kc <= CodeFHighHi))) begin
      code_en = 1'b1;
    end
  end

  // Boosted set membership: a zero slot never matches.
  logic in_set1, in_set2;

  always_comb begin
    in_set1 = 1'b0;
    in_set2 = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      if (boost1_slots_r[i*SlotW +: SlotW] != '0 &&
          boost1_slots_r[i*SlotW +: SlotW] == kc8) in_set1 = 1'b1;
      if (boost2_slots_r[i*SlotW +: SlotW] != '0 &&
          boost2_slots_r[i*SlotW +: SlotW] == kc8) in_set2 = 1'b1;
    end
  end

  // Elapsed time since the stamp, modulo 2^16.
  logic [TimeW-1:0] elapsed;
  assign elapsed = in_word_r.now_ms - stamp_ms_r;

  // Decision and next state for the word in the input register.
  always_comb begin
    holding_nxt      = holding_r;
    repeating_nxt    = repeating_r;
    press_sent_nxt   = press_sent_r;
    held_code_nxt    = held_code_r;
    stamp_ms_nxt     = stamp_ms_r;
    active_delay_nxt = active_delay_r;
    active_term_nxt  = active_term_r;
    result           = '{emit_kind: KindNone, emit_code: '0, pass_through: 1'b0};

    if (in_word_r.action == ActKey) begin
      if (!in_word_r.fast_layer_on) begin
        // Leaving the fast layer cancels the hold.
        holding_nxt         = 1'b0;
        repeating_nxt       = 1'b0;
        result.pass_through = 1'b1;
      end else if (!code_en) begin
        result.pass_through = 1'b1;
      end else if (in_word_r.key_down) begin
        if (kc8 != held_code_r) repeating_nxt = 1'b0;
        result.emit_kind = KindPress;
        result.emit_code = kc8;
        if (in_set1) begin
          active_delay_nxt = boost1_delay_r;
          active_term_nxt  = boost1_term_r;
        end else if (in_set2) begin
          active_delay_nxt = boost2_delay_r;
          active_term_nxt  = boost2_term_r;
        end else begin
          active_delay_nxt = normal_delay_r;
          active_term_nxt  = normal_term_r;
        end
        held_code_nxt = kc8;
        holding_nxt   = 1'b1;
        stamp_ms_nxt  = in_word_r.now_ms;
      end else begin
        result.emit_kind = KindRelease;
        result.emit_code = kc8;
        if (kc8 == held_code_r) begin
          holding_nxt      = 1'b0;
          repeating_nxt    = 1'b0;
          press_sent_nxt   = 1'b0;
          active_delay_nxt = normal_delay_r;
          active_term_nxt  = normal_term_r;
        end
      end
    end else if (holding_r) begin
      // Scan tick: start repeating after the delay, then toggle each term.
      if (!repeating_r) begin
        if (elapsed > active_delay_r) begin
          repeating_nxt  = 1'b1;
          press_sent_nxt = 1'b1;
          stamp_ms_nxt   = in_word_r.now_ms;
        end
      end else if (!press_sent_r) begin
        result.emit_kind = KindPress;
        result.emit_code = held_code_r;
        press_sent_nxt   = 1'b1;
      end else if (elapsed > {{(TimeW-TermW){1'b0}}, active_term_r}) begin
        stamp_ms_nxt     = in_word_r.now_ms;
        result.emit_kind = KindRelease;
        result.emit_code = held_code_r;
        press_sent_nxt   = 1'b0;
      end
    end
  end

  // State update as each word passes to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r      <= 1'b0;
      repeating_r    <= 1'b0;
      press_sent_r   <= 1'b0;
      held_code_r    <= '0;
      stamp_ms_r     <= '0;
      active_delay_r <= DelayRst;
      active_term_r  <= TermRst;
    end else if (advance) begin
      holding_r      <= holding_nxt;
      repeating_r    <= repeating_nxt;
      press_sent_r   <= press_sent_nxt;
      held_code_r    <= held_code_nxt;
      stamp_ms_r     <= stamp_ms_nxt;
      active_delay_r <= active_delay_nxt;
      active_term_r  <= active_term_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_emit_kind    = out_word_r.emit_kind;
  assign out_emit_code    = out_word_r.emit_code;
  assign out_pass_through = out_word_r.pass_through;

  // Checks on the hold state and result words.
`include "key_autorepeat_engine_top_macros.svh"

  `KAR_ASSERT_IMPL(a_repeat_needs_hold, repeating_r, holding_r, "repeating without a held key")
  `KAR_ASSERT_IMPL(a_pass_no_emit, out_valid_r && out_word_r.pass_through,
                   out_word_r.emit_kind == KindNone, "passed word also emits")
  `KAR_ASSERT_IMPL(a_idle_code_zero, out_valid_r && out_word_r.emit_kind == KindNone,
                   out_word_r.emit_code == '0, "code set with nothing emitted")
  `KAR_ASSERT_IMPL(a_emit_code_range, out_valid_r && out_word_r.emit_kind != KindNone,
                   out_word_r.emit_code >= CodeLetterLo[CodeW-1:0] &&
                   out_word_r.emit_code <= CodeFHighHi[CodeW-1:0],
                   "emitted code outside enabled range")
  `KAR_ASSERT_NEXT(a_input_kept, in_valid_r && !advance, in_valid_r, "stalled input word lost")

endmodule
